/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define OSTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is asserted
`define OSTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ostt_pkg.sv */
`default_nettype none

package ostt_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int SLOT_W    = 4;
    localparam int TICK_W    = 32;
    localparam int TAG_W     = 16;

    typedef logic [1:0]        t_op;
    typedef logic [1:0]        t_kind;
    typedef logic [1:0]        t_status;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [TICK_W-1:0] t_ticks;
    typedef logic [TAG_W-1:0]  t_tag;

    // request operations
    localparam t_op OP_TICK    = 2'd0;
    localparam t_op OP_ADD     = 2'd1;
    localparam t_op OP_RELEASE = 2'd2;
    localparam t_op OP_CANCEL  = 2'd3;

    // result kinds
    localparam t_kind KIND_ADD_DONE  = 2'd0;
    localparam t_kind KIND_EXPIRED   = 2'd1;
    localparam t_kind KIND_TICK_DONE = 2'd2;
    localparam t_kind KIND_REL_DONE  = 2'd3;

    // result status
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_WRAP    = 2'd2;
    localparam t_status ST_NOT_USE = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic advance;
        logic add_commit;
        logic tick_eval;
        logic tick_done;
        logic relcan_commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic can_emit;
        logic cur_free;
        logic cur_fire;
        logic idx_last;
    } t_stat;

endpackage

`default_nettype wire

/* hw/rtl/ostt_req_if.sv */
`default_nettype none

interface ostt_req_if;
    import ostt_pkg::*;

    logic   valid;
    logic   ready;
    t_op    operation;
    t_slot  slot;
    t_ticks delay;
    t_tag   tag;

    modport source (output valid, operation, slot, delay, tag, input ready);
    modport sink   (input valid, operation, slot, delay, tag, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ostt_res_if.sv */
`default_nettype none

interface ostt_res_if;
    import ostt_pkg::*;

    logic    valid;
    logic    ready;
    t_kind   kind;
    t_slot   result_slot;
    t_status status;
    t_ticks  now_ticks;
    t_tag    result_tag;
    logic    last;

    modport source (output valid, kind, result_slot, status, now_ticks, result_tag, last,
                    input ready);
    modport sink   (input valid, kind, result_slot, status, now_ticks, result_tag, last,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/ostt_ctrl.sv */
`default_nettype none
`include "assert_macros.svh"

module ostt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  ostt_pkg::t_op     i_req_op,
    output logic              o_req_ready,
    input  ostt_pkg::t_stat   i_stat,
    output ostt_pkg::t_cmd    o_cmd
);
    import ostt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_TICK   = 3'd2;
    localparam logic [2:0] S_DONE   = 3'd3;
    localparam logic [2:0] S_RELCAN = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_req_op) inside
                        OP_TICK:             n_state = S_TICK;
                        OP_ADD:              n_state = S_ADD;
                        OP_RELEASE, OP_CANCEL: n_state = S_RELCAN;
                        default:             n_state = S_RELCAN;
                    endcase
                end
            end
            S_ADD: begin
                // stop on the first free slot or at the end of the table
                if (i_stat.cur_free || i_stat.idx_last) begin
                    if (i_stat.can_emit) begin
                        o_cmd.add_commit = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_TICK: begin
                // a firing slot waits for room in the output register
                if (!i_stat.cur_fire || i_stat.can_emit) begin
                    o_cmd.tick_eval = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.can_emit) begin
                    o_cmd.tick_done = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_RELCAN: begin
                if (i_stat.can_emit) begin
                    o_cmd.relcan_commit = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `OSTT_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, o_cmd.accept, r_state != S_IDLE, "accepted request did not start work")
    `OSTT_ASSERT_IMP(a_one_action, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.accept, o_cmd.add_commit, o_cmd.tick_eval, o_cmd.tick_done, o_cmd.relcan_commit}), "conflicting commands")

endmodule

`default_nettype wire

/* hw/rtl/ostt_dp.sv */
`default_nettype none
`include "assert_macros.svh"

module ostt_dp #(
    parameter int SLOTS = ostt_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ostt_pkg::t_cmd    i_cmd,
    output ostt_pkg::t_stat   o_stat,
    input  ostt_pkg::t_op     i_op,
    input  ostt_pkg::t_slot   i_slot,
    input  ostt_pkg::t_ticks  i_delay,
    input  ostt_pkg::t_tag    i_tag,
    ostt_res_if.source        o_res
);
    import ostt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    typedef logic [IDX_W-1:0] t_idx;
    localparam t_idx LAST_IDX = t_idx'(SLOTS - 1);

    // scan index and request registers
    t_idx   r_idx, n_idx;
    t_ticks r_tick, n_tick;
    t_op    r_op;
    t_slot  r_slot;
    t_tag   r_tag;
    t_ticks r_deadline_new;
    logic   r_wrap;

    // slot flags
    logic [SLOTS-1:0] r_in_use, n_in_use;
    logic [SLOTS-1:0] r_cancelled, n_cancelled;
    logic [SLOTS-1:0] r_held, n_held;

    // deadline and tag store
    t_ticks mem_deadline [SLOTS];
    t_tag   mem_tag      [SLOTS];
    t_ticks r_rd_deadline;
    t_tag   r_rd_tag;

    // output register
    logic    r_out_valid, n_out_valid;
    t_kind   r_kind, n_kind;
    t_slot   r_res_slot, n_res_slot;
    t_status r_status, n_status;
    t_ticks  r_res_ticks, n_res_ticks;
    t_tag    r_res_tag, n_res_tag;
    logic    r_last, n_last;

    logic          cur_in_use, cur_cancelled, cur_held, cur_fire, cur_gone;
    logic          can_emit, emit, slot_in_range, rel_ok;
    logic [TICK_W:0] add_sum;

    assign cur_in_use    = r_in_use[r_idx];
    assign cur_cancelled = r_cancelled[r_idx];
    assign cur_held      = r_held[r_idx];
    assign cur_fire      = cur_in_use && !cur_cancelled && (r_rd_deadline < r_tick);
    assign cur_gone      = (cur_cancelled || cur_fire) && !cur_held;
    assign can_emit      = !r_out_valid || o_res.ready;
    assign slot_in_range = int'(r_slot) < SLOTS;
    assign rel_ok        = slot_in_range && cur_in_use;
    assign add_sum       = {1'b0, r_tick} + {1'b0, i_delay};

    assign emit = i_cmd.add_commit || (i_cmd.tick_eval && cur_fire) ||
                  i_cmd.tick_done || i_cmd.relcan_commit;

    assign o_stat.can_emit = can_emit;
    assign o_stat.cur_free = !cur_in_use;
    assign o_stat.cur_fire = cur_fire;
    assign o_stat.idx_last = (r_idx == LAST_IDX);

    always_comb begin
        n_idx  = r_idx;
        n_tick = r_tick;
        if (i_cmd.accept) begin
            if (i_op == OP_RELEASE || i_op == OP_CANCEL) begin
                n_idx = t_idx'(i_slot);
            end else begin
                n_idx = '0;
            end
            if (i_op == OP_TICK) begin
                n_tick = r_tick + t_ticks'(1);
            end
        end else if (i_cmd.advance) begin
            n_idx = t_idx'(r_idx + 1'b1);
        end
    end

    always_comb begin
        n_in_use    = r_in_use;
        n_cancelled = r_cancelled;
        n_held      = r_held;
        if (i_cmd.add_commit && !cur_in_use) begin
            n_in_use[r_idx]    = 1'b1;
            n_cancelled[r_idx] = 1'b0;
            n_held[r_idx]      = 1'b1;
        end
        if (i_cmd.tick_eval && cur_in_use) begin
            if (cur_gone) begin
                n_in_use[r_idx]    = 1'b0;
                n_cancelled[r_idx] = 1'b0;
            end else begin
                n_cancelled[r_idx] = cur_cancelled || cur_fire;
            end
        end
        if (i_cmd.relcan_commit && rel_ok) begin
            n_held[r_idx] = 1'b0;
            if (r_op == OP_CANCEL) begin
                n_cancelled[r_idx] = 1'b1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_res.ready;
        n_kind      = r_kind;
        n_res_slot  = r_res_slot;
        n_status    = r_status;
        n_res_ticks = r_res_ticks;
        n_res_tag   = r_res_tag;
        n_last      = r_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_res_ticks = r_tick;
        end
        if (i_cmd.add_commit) begin
            n_kind    = KIND_ADD_DONE;
            n_res_tag = r_tag;
            n_last    = 1'b1;
            if (cur_in_use) begin
                n_res_slot = '0;
                n_status   = ST_FULL;
            end else begin
                n_res_slot = t_slot'(r_idx);
                n_status   = r_wrap ? ST_WRAP : ST_OK;
            end
        end else if (i_cmd.tick_eval && cur_fire) begin
            n_kind     = KIND_EXPIRED;
            n_res_slot = t_slot'(r_idx);
            n_status   = ST_OK;
            n_res_tag  = r_rd_tag;
            n_last     = 1'b0;
        end else if (i_cmd.tick_done) begin
            n_kind     = KIND_TICK_DONE;
            n_res_slot = '0;
            n_status   = ST_OK;
            n_res_tag  = '0;
            n_last     = 1'b1;
        end else if (i_cmd.relcan_commit) begin
            n_kind     = KIND_REL_DONE;
            n_res_slot = r_slot;
            n_status   = rel_ok ? ST_OK : ST_NOT_USE;
            n_res_tag  = '0;
            n_last     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_tick      <= '0;
            r_in_use    <= '0;
            r_cancelled <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_tick      <= n_tick;
            r_in_use    <= n_in_use;
            r_cancelled <= n_cancelled;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op           <= i_op;
            r_slot         <= i_slot;
            r_tag          <= i_tag;
            r_deadline_new <= add_sum[TICK_W-1:0];
            r_wrap         <= add_sum[TICK_W];
        end
        r_kind      <= n_kind;
        r_res_slot  <= n_res_slot;
        r_status    <= n_status;
        r_res_ticks <= n_res_ticks;
        r_res_tag   <= n_res_tag;
        r_last      <= n_last;
    end

    // one write port, one registered read port that follows the scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_commit && !cur_in_use) begin
            mem_deadline[r_idx] <= r_deadline_new;
            mem_tag[r_idx]      <= r_tag;
        end
        r_rd_deadline <= mem_deadline[n_idx];
        r_rd_tag      <= mem_tag[n_idx];
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_kind;
    assign o_res.result_slot = r_res_slot;
    assign o_res.status      = r_status;
    assign o_res.now_ticks   = r_res_ticks;
    assign o_res.result_tag  = r_res_tag;
    assign o_res.last        = r_last;

    `OSTT_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, emit && r_out_valid, o_res.ready, "result overwritten before taken")
    `OSTT_ASSERT_IMP(a_tick_on_request, i_clk, i_rst_n, $past(i_rst_n) && (r_tick != $past(r_tick)), $past(i_cmd.accept && (i_op == OP_TICK)), "tick counter moved without a tick request")

endmodule

`default_nettype wire

/* hw/rtl/one_shot_timer_table.sv */
`default_nettype none

// One-shot timer table with SLOTS fixed slots. Each request on i_req is one
// operation: tick, add, release or cancel. Add takes the lowest free slot,
// arms it with deadline = now + delay (mod 2^32, status 2 when it wraps) and
// answers when the slot search, which walks one slot per cycle, finds a free
// slot or reaches the end of the table. Release and cancel answer with one
// result. A tick bumps the counter and walks every slot in index order, one
// slot per cycle while the result channel keeps up, through the single read
// port of the deadline and tag store, emitting one expiry result per slot that
// fires and then a done result with last set. Only one request is worked on
// at a time; the output register lets the next request in while the final
// result of the previous one still waits to be taken.
module one_shot_timer_table #(
    parameter int SLOTS = ostt_pkg::SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ostt_req_if.sink   i_req,
    ostt_res_if.source o_res
);
    import ostt_pkg::*;

    // command and status between the sequencer and the datapath
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_ready;

    // request handshake is owned by the sequencer: ready only between requests
    assign i_req.ready = w_ready;

    // sequencer: idle, slot search for add, tick scan, tick done,
    // release or cancel answer
    ostt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.operation),
        .o_req_ready (w_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: tick counter, slot flags, deadline and tag store,
    // output register
    ostt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_op    (i_req.operation),
        .i_slot  (i_req.slot),
        .i_delay (i_req.delay),
        .i_tag   (i_req.tag),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
